>>> rtl/generational_handle_allocator_defines.svh
// assertion helpers for the handle allocator
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define GHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gha_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned GEN_W = 8;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] entity_index;
    logic [GEN_W-1:0] entity_generation;
  } gha_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic             handle_valid;
    logic [1:0]       status;
  } gha_rsp_t;

  typedef struct packed {
    logic nonempty;
    logic notfull;
  } gha_fifo_stat_t;

endpackage
`default_nettype wire

>>> rtl/gha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gha_req_if;
  import gha_pkg::*;
  logic     valid;
  logic     ready;
  gha_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gha_rsp_if;
  import gha_pkg::*;
  logic     valid;
  logic     ready;
  gha_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/generational_handle_allocator.sv
// channel  dir  payload                                              handshake
// req_i    in   cmd, entity_index, entity_generation                 valid/ready
// rsp_o    out  out_index, out_generation, handle_valid, status      valid/ready
//
// one command at a time; fresh create, full, or out-of-range handle skip the reads,
// destroy/check read the slot table, and create from the free fifo reads the fifo
// then the slot table; each memory port has a registered read
// no clearing pass after reset: slots at or above the fresh counter count as untouched
// a new command is taken while the previous result waits in the output register;
// it then holds in its final step until that register frees up
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_allocator_defines.svh"
module generational_handle_allocator #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gha_req_if.sink    req_i,
  gha_rsp_if.source  rsp_o
);
  import gha_pkg::*;

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = SW + 1;
  localparam int unsigned EW = GEN_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [GEN_W-1:0] hgen_q, hgen_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [GEN_W-1:0] egen_q, egen_d;
  logic             hit_q, hit_d;
  logic [CW-1:0]    fresh_q, fresh_d;
  gha_rsp_t         rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic             accept, out_free, done_fire;
  logic [31:0]      idx_ext, slot_ext;
  logic             in_range, fresh_ok;

  logic             fifo_pop, fifo_push;
  logic [SW-1:0]    fifo_rdata;
  gha_fifo_stat_t   fifo_stat;

  logic             tbl_we, tbl_re;
  logic [SW-1:0]    tbl_raddr;
  logic [EW-1:0]    tbl_wdata, tbl_rdata;

  gha_free_fifo #(.DEPTH(SLOT_COUNT)) u_free_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (fifo_pop),
    .push_i      (fifo_push),
    .push_data_i (slot_q),
    .pop_data_o  (fifo_rdata),
    .stat_o      (fifo_stat)
  );

  gha_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_slot_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot_q),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign done_fire     = (state_q == S_DONE) && out_free;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  assign idx_ext  = 32'(req_i.payload.entity_index);
  assign slot_ext = 32'(slot_q);
  assign in_range = (idx_ext != 32'd0) && (idx_ext < 32'(fresh_q));
  assign fresh_ok = 32'(fresh_q) < SLOT_COUNT;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    hgen_d    = hgen_q;
    slot_d    = slot_q;
    egen_d    = egen_q;
    hit_d     = hit_q;
    fresh_d   = fresh_q;
    fifo_pop  = 1'b0;
    fifo_push = 1'b0;
    tbl_re    = 1'b0;
    tbl_we    = 1'b0;
    tbl_raddr = fifo_rdata;
    tbl_wdata = {1'b0, egen_q};
    rsp_d     = rsp_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = req_i.payload.cmd;
          idx_d  = req_i.payload.entity_index;
          hgen_d = req_i.payload.entity_generation;
          if (req_i.payload.cmd == CMD_CREATE) begin
            if (fifo_stat.nonempty) begin
              fifo_pop = 1'b1;
              state_d  = S_POP;
            end else if (fresh_ok) begin
              slot_d  = fresh_q[SW-1:0];
              egen_d  = '0;
              hit_d   = 1'b1;
              fresh_d = fresh_q + CW'(1);
              state_d = S_DONE;
            end else begin
              hit_d   = 1'b0;
              state_d = S_DONE;
            end
          end else if (in_range) begin
            tbl_re    = 1'b1;
            tbl_raddr = idx_ext[SW-1:0];
            slot_d    = idx_ext[SW-1:0];
            state_d   = S_READ;
          end else begin
            hit_d   = 1'b0;
            state_d = S_DONE;
          end
        end
      end
      S_POP: begin
        tbl_re    = 1'b1;
        tbl_raddr = fifo_rdata;
        slot_d    = fifo_rdata;
        state_d   = S_READ;
      end
      S_READ: begin
        egen_d  = tbl_rdata[GEN_W-1:0];
        hit_d   = (cmd_q == CMD_CREATE) ||
                  (tbl_rdata[GEN_W] && (tbl_rdata[GEN_W-1:0] == hgen_q));
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (cmd_q == CMD_CREATE) begin
            tbl_we    = hit_q;
            tbl_wdata = {1'b1, egen_q};
            if (hit_q) begin
              rsp_d = '{out_index: slot_ext[IDX_W-1:0], out_generation: egen_q,
                        handle_valid: 1'b1, status: ST_OK};
            end else begin
              rsp_d = '{out_index: '0, out_generation: '0,
                        handle_valid: 1'b0, status: ST_FULL};
            end
          end else begin
            if (cmd_q == CMD_DESTROY) begin
              tbl_we    = hit_q;
              tbl_wdata = {1'b0, egen_q + GEN_W'(1)};
              fifo_push = hit_q && fifo_stat.notfull;
            end
            rsp_d = '{out_index: idx_q, out_generation: hgen_q,
                      handle_valid: hit_q, status: hit_q ? ST_OK : ST_INVALID};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (done_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fresh_q     <= CW'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fresh_q     <= fresh_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    hgen_q <= hgen_d;
    slot_q <= slot_d;
    egen_q <= egen_d;
    hit_q  <= hit_d;
    rsp_q  <= rsp_d;
  end

  `GHA_ASSERT_NOW(a_fifo_implies_created, fifo_stat.nonempty, fresh_q > CW'(1), "free fifo holds slots that were never created")
  `GHA_ASSERT_NEXT(a_create_pops, accept && (req_i.payload.cmd == CMD_CREATE) && fifo_stat.nonempty, state_q == S_POP, "create skipped the free fifo")
  `GHA_ASSERT_NOW(a_full_result, rsp_valid_q && (rsp_q.status == ST_FULL), (rsp_q.out_index == '0) && !rsp_q.handle_valid, "full result carries a handle")

endmodule
`default_nettype wire

>>> rtl/gha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/gha_free_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module gha_free_fifo #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_i,
  input  logic                    push_i,
  input  logic [AW-1:0]           push_data_i,
  output logic [AW-1:0]           pop_data_o,
  output gha_pkg::gha_fifo_stat_t stat_o
);
  import gha_pkg::*;

  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW:0]   count_q, count_d;

  gha_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (tail_q),
    .wdata_i (push_data_i),
    .re_i    (pop_i),
    .raddr_i (head_q),
    .rdata_o (pop_data_o)
  );

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop_i) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + AW'(1);
    end
    if (push_i) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.notfull  = (32'(count_q) < DEPTH);

endmodule
`default_nettype wire
